// ===== src/assert_macros.svh =====
// Assertion macros shared by the checking code of the block.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ttp_pkg.sv =====
package ttp_pkg;

	// Fixed widths of the ports.
	localparam int CHUNK_ID_W = 12;
	localparam int POS_OUT_W  = 12;
	localparam int SLOT_OUT_W = 6;
	localparam int TOTAL_W    = 32;

	// Read and write strobes from the sequencer to the memories.
	typedef struct packed {
		logic map_re;
		logic ord_re;
		logic map_we;
		logic res_we;
		logic comp_we;
	} ttp_mem_ctl_t;

endpackage

// ===== src/ttp_chunk_map.sv =====
module ttp_chunk_map #(
	parameter int NUM_CHUNKS = 4096,
	localparam int CW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1
) (
	input  logic                  clk,
	input  ttp_pkg::ttp_mem_ctl_t ctl,
	input  logic [CW-1:0]         rd_addr,
	output logic                  rd_tier,
	output logic [CW-1:0]         rd_pos,
	input  logic [CW-1:0]         wr_addr,
	input  logic                  wr_tier,
	input  logic [CW-1:0]         wr_pos
);
	import ttp_pkg::*;

	// One entry per chunk: its tier and its position within that tier.
	logic [CW:0] map_mem [NUM_CHUNKS];
	logic [CW:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (ctl.map_we) begin
			map_mem[wr_addr] <= {wr_tier, wr_pos};
		end
	end

	// Read port with a registered output.
	always_ff @(posedge clk) begin
		if (ctl.map_re) begin
			rd_data_q <= map_mem[rd_addr];
		end
	end

	assign rd_tier = rd_data_q[CW];
	assign rd_pos  = rd_data_q[CW-1:0];

endmodule

// ===== src/ttp_order_store.sv =====
module ttp_order_store #(
	parameter int NUM_CHUNKS = 4096,
	parameter int FULL_SLOTS = 64,
	localparam int CW  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1,
	localparam int SW  = (FULL_SLOTS > 1) ? $clog2(FULL_SLOTS) : 1,
	localparam int CS  = NUM_CHUNKS - FULL_SLOTS,
	localparam int CAW = (CS > 1) ? $clog2(CS) : 1
) (
	input  logic                  clk,
	input  ttp_pkg::ttp_mem_ctl_t ctl,
	input  logic [SW-1:0]         res_rd_addr_a,
	input  logic [SW-1:0]         res_rd_addr_b,
	output logic [CW-1:0]         res_rd_chunk_a,
	output logic [SW-1:0]         res_rd_slot_a,
	output logic [CW-1:0]         res_rd_chunk_b,
	output logic [SW-1:0]         res_rd_slot_b,
	input  logic [SW-1:0]         res_wr_addr,
	input  logic [CW-1:0]         res_wr_chunk,
	input  logic [SW-1:0]         res_wr_slot,
	input  logic [CAW-1:0]        comp_rd_addr,
	output logic [CW-1:0]         comp_rd_chunk,
	input  logic [CAW-1:0]        comp_wr_addr,
	input  logic [CW-1:0]         comp_wr_chunk
);
	import ttp_pkg::*;

	// Resident order: chunk and data slot per position, two read ports.
	logic [CW+SW-1:0] res_mem [FULL_SLOTS];
	logic [CW+SW-1:0] res_a_q;
	logic [CW+SW-1:0] res_b_q;
	// Compact order: chunk per position.
	logic [CW-1:0]    comp_mem [CS];
	logic [CW-1:0]    comp_q;

	// Write ports.
	always_ff @(posedge clk) begin
		if (ctl.res_we) begin
			res_mem[res_wr_addr] <= {res_wr_chunk, res_wr_slot};
		end
		if (ctl.comp_we) begin
			comp_mem[comp_wr_addr] <= comp_wr_chunk;
		end
	end

	// Registered reads of both orders.
	always_ff @(posedge clk) begin
		if (ctl.ord_re) begin
			res_a_q <= res_mem[res_rd_addr_a];
			res_b_q <= res_mem[res_rd_addr_b];
			comp_q  <= comp_mem[comp_rd_addr];
		end
	end

	assign res_rd_chunk_a = res_a_q[CW+SW-1:SW];
	assign res_rd_slot_a  = res_a_q[SW-1:0];
	assign res_rd_chunk_b = res_b_q[CW+SW-1:SW];
	assign res_rd_slot_b  = res_b_q[SW-1:0];
	assign comp_rd_chunk  = comp_q;

endmodule

// ===== src/ttp_seq.sv =====
`include "assert_macros.svh"

module ttp_seq #(
	parameter int NUM_CHUNKS = 4096,
	parameter int FULL_SLOTS = 64,
	localparam int CW  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1,
	localparam int SW  = (FULL_SLOTS > 1) ? $clog2(FULL_SLOTS) : 1,
	localparam int CS  = NUM_CHUNKS - FULL_SLOTS,
	localparam int CAW = (CS > 1) ? $clog2(CS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ttp_pkg::CHUNK_ID_W-1:0]  chunk_id,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            tier_after,
	output logic [ttp_pkg::POS_OUT_W-1:0]   position_after,
	output logic [ttp_pkg::SLOT_OUT_W-1:0]  data_slot,
	output logic                            moved,
	output logic                            promoted,
	output logic [ttp_pkg::CHUNK_ID_W-1:0]  demoted_chunk,
	output logic [ttp_pkg::TOTAL_W-1:0]     promotion_total,
	output ttp_pkg::ttp_mem_ctl_t           ctl,
	output logic [CW-1:0]                   map_rd_addr,
	input  logic                            map_rd_tier,
	input  logic [CW-1:0]                   map_rd_pos,
	output logic [CW-1:0]                   map_wr_addr,
	output logic                            map_wr_tier,
	output logic [CW-1:0]                   map_wr_pos,
	output logic [SW-1:0]                   res_rd_addr_a,
	output logic [SW-1:0]                   res_rd_addr_b,
	input  logic [CW-1:0]                   res_rd_chunk_a,
	input  logic [SW-1:0]                   res_rd_slot_a,
	input  logic [CW-1:0]                   res_rd_chunk_b,
	input  logic [SW-1:0]                   res_rd_slot_b,
	output logic [SW-1:0]                   res_wr_addr,
	output logic [CW-1:0]                   res_wr_chunk,
	output logic [SW-1:0]                   res_wr_slot,
	output logic [CAW-1:0]                  comp_rd_addr,
	input  logic [CW-1:0]                   comp_rd_chunk,
	output logic [CAW-1:0]                  comp_wr_addr,
	output logic [CW-1:0]                   comp_wr_chunk
);
	import ttp_pkg::*;

	localparam logic [SW-1:0] LAST_SLOT = SW'(FULL_SLOTS - 1);
	localparam logic [CW-1:0] LAST_POS  = CW'(FULL_SLOTS - 1);
	localparam logic [CW-1:0] LAST_IDX  = CW'(NUM_CHUNKS - 1);

	typedef enum logic [2:0] {S_IDLE, S_MAP, S_W1, S_W2, S_DONE} state_t;
	typedef enum logic [2:0] {K_NONE, K_FRONT, K_RSWAP, K_PROMO, K_CSWAP} kind_t;

	state_t              state_q;
	kind_t               kind_q;
	kind_t               kind_d;
	logic                init_q;
	logic [CW-1:0]       icnt_q;
	logic [CW-1:0]       c_q;
	logic [CW-1:0]       p_q;
	logic                range_q;
	logic [TOTAL_W-1:0]  count_q;
	logic                out_valid_q;
	logic                tier_q;
	logic [POS_OUT_W-1:0]  pos_q;
	logic [SLOT_OUT_W-1:0] slot_q;
	logic                moved_q;
	logic                promoted_q;
	logic [CHUNK_ID_W-1:0] demoted_q;
	logic [TOTAL_W-1:0]  total_q;

	logic        acc;
	logic        load;
	logic [31:0] cid_w;
	logic        in_range;
	logic [31:0] mpos_w;
	logic [31:0] p_sel;
	logic [31:0] p_selm1;
	logic [31:0] pq_w;
	logic [31:0] pqm1;
	logic [31:0] icnt_w;
	logic [31:0] ioff;
	logic        r_tier;
	logic [31:0] r_pos;
	logic [31:0] r_slot;
	logic        r_moved;
	logic        r_promoted;
	logic [31:0] r_demoted;

	// Input handshake: one request at a time, none during the start-up sweep.
	assign in_stall = init_q || (state_q != S_IDLE);
	assign acc      = in_valid && !in_stall;
	assign cid_w    = 32'(chunk_id);
	assign in_range = cid_w < 32'(NUM_CHUNKS);
	assign map_rd_addr = cid_w[CW-1:0];

	// Classify the request from the chunk map entry and clamp its position.
	always_comb begin
		mpos_w = 32'(map_rd_pos);
		if (!map_rd_tier) begin
			p_sel = (mpos_w >= 32'(FULL_SLOTS)) ? 32'd0 : mpos_w;
		end else begin
			p_sel = (mpos_w >= 32'(CS)) ? 32'(CS - 1) : mpos_w;
		end
		p_selm1 = p_sel - 32'd1;
		if (!range_q) begin
			kind_d = K_NONE;
		end else if (!map_rd_tier) begin
			kind_d = (p_sel == 32'd0) ? K_FRONT : K_RSWAP;
		end else begin
			kind_d = (p_sel == 32'd0) ? K_PROMO : K_CSWAP;
		end
	end

	// Order reads: the neighbour ahead, the entry itself, or the last resident.
	always_comb begin
		case (kind_d)
			K_PROMO: res_rd_addr_a = LAST_SLOT;
			K_RSWAP: res_rd_addr_a = p_selm1[SW-1:0];
			default: res_rd_addr_a = '0;
		endcase
		res_rd_addr_b = p_sel[SW-1:0];
		comp_rd_addr  = p_selm1[CAW-1:0];
	end

	assign pq_w   = 32'(p_q);
	assign pqm1   = pq_w - 32'd1;
	assign icnt_w = 32'(icnt_q);
	assign ioff   = icnt_w - 32'(FULL_SLOTS);

	// Memory strobes and write data: the start-up sweep, then the two write phases.
	always_comb begin
		ctl           = '0;
		ctl.map_re    = acc;
		ctl.ord_re    = (state_q == S_MAP);
		map_wr_addr   = c_q;
		map_wr_tier   = 1'b0;
		map_wr_pos    = '0;
		res_wr_addr   = '0;
		res_wr_chunk  = c_q;
		res_wr_slot   = res_rd_slot_a;
		comp_wr_addr  = '0;
		comp_wr_chunk = c_q;
		if (init_q) begin
			ctl.map_we  = 1'b1;
			map_wr_addr = icnt_q;
			if (icnt_w < 32'(FULL_SLOTS)) begin
				map_wr_pos   = icnt_q;
				ctl.res_we   = 1'b1;
				res_wr_addr  = icnt_w[SW-1:0];
				res_wr_chunk = icnt_q;
				res_wr_slot  = icnt_w[SW-1:0];
			end else begin
				map_wr_tier   = 1'b1;
				map_wr_pos    = ioff[CW-1:0];
				ctl.comp_we   = 1'b1;
				comp_wr_addr  = ioff[CAW-1:0];
				comp_wr_chunk = icnt_q;
			end
		end else if (state_q == S_W1) begin
			case (kind_q)
				K_RSWAP: begin
					ctl.res_we  = 1'b1;
					res_wr_addr = pqm1[SW-1:0];
					res_wr_slot = res_rd_slot_b;
					ctl.map_we  = 1'b1;
					map_wr_pos  = pqm1[CW-1:0];
				end
				K_PROMO: begin
					ctl.comp_we   = 1'b1;
					comp_wr_chunk = res_rd_chunk_a;
					ctl.map_we    = 1'b1;
					map_wr_addr   = res_rd_chunk_a;
					map_wr_tier   = 1'b1;
				end
				K_CSWAP: begin
					ctl.comp_we  = 1'b1;
					comp_wr_addr = pqm1[CAW-1:0];
					ctl.map_we   = 1'b1;
					map_wr_tier  = 1'b1;
					map_wr_pos   = pqm1[CW-1:0];
				end
				default: begin
				end
			endcase
		end else if (state_q == S_W2) begin
			case (kind_q)
				K_RSWAP: begin
					ctl.res_we   = 1'b1;
					res_wr_addr  = p_q[SW-1:0];
					res_wr_chunk = res_rd_chunk_a;
					ctl.map_we   = 1'b1;
					map_wr_addr  = res_rd_chunk_a;
					map_wr_pos   = p_q;
				end
				K_PROMO: begin
					ctl.res_we  = 1'b1;
					res_wr_addr = LAST_SLOT;
					ctl.map_we  = 1'b1;
					map_wr_pos  = LAST_POS;
				end
				K_CSWAP: begin
					ctl.comp_we   = 1'b1;
					comp_wr_addr  = p_q[CAW-1:0];
					comp_wr_chunk = comp_rd_chunk;
					ctl.map_we    = 1'b1;
					map_wr_addr   = comp_rd_chunk;
					map_wr_tier   = 1'b1;
					map_wr_pos    = p_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Result of the request, built from the held order reads.
	always_comb begin
		r_tier     = 1'b0;
		r_pos      = '0;
		r_slot     = '0;
		r_moved    = 1'b0;
		r_promoted = 1'b0;
		r_demoted  = '0;
		case (kind_q)
			K_FRONT: r_slot = 32'(res_rd_slot_a);
			K_RSWAP: begin
				r_pos   = pqm1;
				r_slot  = 32'(res_rd_slot_b);
				r_moved = 1'b1;
			end
			K_PROMO: begin
				r_pos      = 32'(FULL_SLOTS - 1);
				r_slot     = 32'(res_rd_slot_a);
				r_moved    = 1'b1;
				r_promoted = 1'b1;
				r_demoted  = 32'(res_rd_chunk_a);
			end
			K_CSWAP: begin
				r_tier  = 1'b1;
				r_pos   = pqm1;
				r_moved = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// The result register takes a new result once the old one has been transferred.
	assign load = ((state_q == S_W2) || (state_q == S_DONE)) && (!out_valid_q || !out_stall);

	// Sequencer, start-up sweep, promotion counter and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= K_NONE;
			init_q      <= 1'b1;
			icnt_q      <= '0;
			range_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (init_q) begin
				icnt_q <= icnt_q + CW'(1);
				if (icnt_q == LAST_IDX) begin
					init_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						c_q     <= cid_w[CW-1:0];
						range_q <= in_range;
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					kind_q  <= kind_d;
					p_q     <= p_sel[CW-1:0];
					state_q <= S_W1;
				end
				S_W1: begin
					if (kind_q == K_PROMO) begin
						count_q <= count_q + TOTAL_W'(1);
					end
					state_q <= S_W2;
				end
				S_W2: begin
					state_q <= load ? S_IDLE : S_DONE;
				end
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
				tier_q      <= r_tier;
				pos_q       <= r_pos[POS_OUT_W-1:0];
				slot_q      <= r_slot[SLOT_OUT_W-1:0];
				moved_q     <= r_moved;
				promoted_q  <= r_promoted;
				demoted_q   <= r_demoted[CHUNK_ID_W-1:0];
				total_q     <= count_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign tier_after      = tier_q;
	assign position_after  = pos_q;
	assign data_slot       = slot_q;
	assign moved           = moved_q;
	assign promoted        = promoted_q;
	assign demoted_chunk   = demoted_q;
	assign promotion_total = total_q;

	// Checks on the sequencing.
	`TTP_ASSERT_NXT(a_accept_reads_map, acc, state_q == S_MAP,
		"accepted request did not go on to the map read")
	`TTP_ASSERT_IMP(a_write_only_busy, ctl.map_we || ctl.res_we || ctl.comp_we,
		init_q || state_q == S_W1 || state_q == S_W2, "memory write outside a write phase")
	`TTP_ASSERT_IMP(a_order_write_maps, ctl.res_we || ctl.comp_we, ctl.map_we,
		"order written without its chunk map entry")
	`TTP_ASSERT_IMP(a_count_on_promotion, count_q != $past(count_q),
		$past(state_q == S_W1 && kind_q == K_PROMO), "promotion counter changed without a promotion")
	`TTP_ASSERT_IMP(a_swap_reads_self, state_q == S_W1 && kind_q == K_RSWAP,
		res_rd_chunk_b == c_q, "resident entry at the chunk's position holds another chunk")

endmodule

// ===== src/two_tier_transpose_priority_core.sv =====
// Two-tier transpose priority list. Each request names a chunk that moves one place towards
// the front of its tier unless it is at the front already; a compact-tier chunk at the front
// is promoted into the last resident position and the chunk there is demoted. Every request
// passes through one chunk map read, one read of the order memories, and two write phases,
// since each memory has a single write port and a swap updates two entries of it. A new
// request is taken while the previous result still waits in the output register. After
// reset the block runs a start-up sweep over all NUM_CHUNKS chunk map entries that loads the
// initial orders into the memories, and holds in_stall high until it ends.
module two_tier_transpose_priority_core #(
	parameter int NUM_CHUNKS = 4096,
	parameter int FULL_SLOTS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ttp_pkg::CHUNK_ID_W-1:0]  chunk_id,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            tier_after,
	output logic [ttp_pkg::POS_OUT_W-1:0]   position_after,
	output logic [ttp_pkg::SLOT_OUT_W-1:0]  data_slot,
	output logic                            moved,
	output logic                            promoted,
	output logic [ttp_pkg::CHUNK_ID_W-1:0]  demoted_chunk,
	output logic [ttp_pkg::TOTAL_W-1:0]     promotion_total
);
	import ttp_pkg::*;

	localparam int CW  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
	localparam int SW  = (FULL_SLOTS > 1) ? $clog2(FULL_SLOTS) : 1;
	localparam int CS  = NUM_CHUNKS - FULL_SLOTS;
	localparam int CAW = (CS > 1) ? $clog2(CS) : 1;

	ttp_mem_ctl_t  ctl;
	logic [CW-1:0] map_rd_addr;
	logic          map_rd_tier;
	logic [CW-1:0] map_rd_pos;
	logic [CW-1:0] map_wr_addr;
	logic          map_wr_tier;
	logic [CW-1:0] map_wr_pos;
	logic [SW-1:0] res_rd_addr_a;
	logic [SW-1:0] res_rd_addr_b;
	logic [CW-1:0] res_rd_chunk_a;
	logic [SW-1:0] res_rd_slot_a;
	logic [CW-1:0] res_rd_chunk_b;
	logic [SW-1:0] res_rd_slot_b;
	logic [SW-1:0] res_wr_addr;
	logic [CW-1:0] res_wr_chunk;
	logic [SW-1:0] res_wr_slot;
	logic [CAW-1:0] comp_rd_addr;
	logic [CW-1:0]  comp_rd_chunk;
	logic [CAW-1:0] comp_wr_addr;
	logic [CW-1:0]  comp_wr_chunk;

	// Sequencer and result register.
	ttp_seq #(
		.NUM_CHUNKS(NUM_CHUNKS),
		.FULL_SLOTS(FULL_SLOTS)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.chunk_id       (chunk_id),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tier_after     (tier_after),
		.position_after (position_after),
		.data_slot      (data_slot),
		.moved          (moved),
		.promoted       (promoted),
		.demoted_chunk  (demoted_chunk),
		.promotion_total(promotion_total),
		.ctl            (ctl),
		.map_rd_addr    (map_rd_addr),
		.map_rd_tier    (map_rd_tier),
		.map_rd_pos     (map_rd_pos),
		.map_wr_addr    (map_wr_addr),
		.map_wr_tier    (map_wr_tier),
		.map_wr_pos     (map_wr_pos),
		.res_rd_addr_a  (res_rd_addr_a),
		.res_rd_addr_b  (res_rd_addr_b),
		.res_rd_chunk_a (res_rd_chunk_a),
		.res_rd_slot_a  (res_rd_slot_a),
		.res_rd_chunk_b (res_rd_chunk_b),
		.res_rd_slot_b  (res_rd_slot_b),
		.res_wr_addr    (res_wr_addr),
		.res_wr_chunk   (res_wr_chunk),
		.res_wr_slot    (res_wr_slot),
		.comp_rd_addr   (comp_rd_addr),
		.comp_rd_chunk  (comp_rd_chunk),
		.comp_wr_addr   (comp_wr_addr),
		.comp_wr_chunk  (comp_wr_chunk)
	);

	// Reverse map from chunk to tier and position.
	ttp_chunk_map #(
		.NUM_CHUNKS(NUM_CHUNKS)
	) u_chunk_map (
		.clk    (clk),
		.ctl    (ctl),
		.rd_addr(map_rd_addr),
		.rd_tier(map_rd_tier),
		.rd_pos (map_rd_pos),
		.wr_addr(map_wr_addr),
		.wr_tier(map_wr_tier),
		.wr_pos (map_wr_pos)
	);

	// Resident and compact orders.
	ttp_order_store #(
		.NUM_CHUNKS(NUM_CHUNKS),
		.FULL_SLOTS(FULL_SLOTS)
	) u_order_store (
		.clk           (clk),
		.ctl           (ctl),
		.res_rd_addr_a (res_rd_addr_a),
		.res_rd_addr_b (res_rd_addr_b),
		.res_rd_chunk_a(res_rd_chunk_a),
		.res_rd_slot_a (res_rd_slot_a),
		.res_rd_chunk_b(res_rd_chunk_b),
		.res_rd_slot_b (res_rd_slot_b),
		.res_wr_addr   (res_wr_addr),
		.res_wr_chunk  (res_wr_chunk),
		.res_wr_slot   (res_wr_slot),
		.comp_rd_addr  (comp_rd_addr),
		.comp_rd_chunk (comp_rd_chunk),
		.comp_wr_addr  (comp_wr_addr),
		.comp_wr_chunk (comp_wr_chunk)
	);

endmodule
